/* design/tnds_pkg.sv */
package tnds_pkg;

  // song memory geometry
  localparam int SONG_DEPTH = 256;
  localparam int ADDR_W     = $clog2(SONG_DEPTH);

  // note numbering
  localparam int NOTE_COUNT = 72;
  localparam logic [7:0] NOTE_LIMIT = 8'(NOTE_COUNT);

  // configuration register indexes
  localparam logic [2:0] CFG_PLAYING     = 3'd0;
  localparam logic [2:0] CFG_SONG_LENGTH = 3'd1;
  localparam logic [2:0] CFG_BASS        = 3'd2;
  localparam logic [2:0] CFG_SNARE       = 3'd3;
  localparam logic [2:0] CFG_HIT         = 3'd4;

  // drum codes
  localparam logic [1:0] DRUM_NONE  = 2'd0;
  localparam logic [1:0] DRUM_BASS  = 2'd1;
  localparam logic [1:0] DRUM_SNARE = 2'd2;
  localparam logic [1:0] DRUM_HIT   = 2'd3;

  // input kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // note to channel frequency
  localparam logic [10:0] FREQ_TABLE [NOTE_COUNT] = '{
    11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
    11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
    11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
    11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
    11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
    11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
    11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
    11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
    11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
    11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
    11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
    11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
  };

  typedef struct packed {
    logic        trig;
    logic [10:0] freq;
  } chan_t;

  // song memory access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // out-of-table notes (silence included) give no trigger and zero frequency
  function automatic chan_t note_lookup(input logic [7:0] note);
    chan_t c;
    c.trig = 1'b0;
    c.freq = '0;
    if (note < NOTE_LIMIT) begin
      c.trig = 1'b1;
      c.freq = FREQ_TABLE[note[6:0]];
    end
    return c;
  endfunction

endpackage

/* design/tracker_note_drum_sequencer.sv */
// Channel   Handshake              Payload
// s_        s_tvalid / s_tready    tdata: load_address, load_data; tuser: opcode
// m_        m_tvalid / m_tready    tdata: drum_kind, pulse/wave trigger + freq
// cfg_      cfg_we (no wait)       cfg_index, cfg_data
//
// Loads and non-wave ticks are taken one per cycle while the output is not stalled;
// a tick's result passes the song memory read register (p1) and the output register.
// A tick whose first byte carries the wave flag holds the input while the single
// song memory read port fetches the second byte; its result passes p1, p2 and the
// output register. rst clears configuration, position and pipe valids; payload
// registers and song memory are not cleared. A stalled output holds pipe and input.
module tracker_note_drum_sequencer
  import tnds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] load_address, [15:8] load_data
  input  logic        s_tuser,   // [0] opcode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] drum_kind, [2] pulse_trigger,
                                 // [13:3] pulse_frequency, [14] wave_trigger,
                                 // [25:15] wave_frequency, [31:26] zero
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic        playing;
  logic [8:0]  song_length;
  logic [15:0] bass_pattern;
  logic [15:0] snare_pattern;
  logic [15:0] hit_mask;

  // playback position
  logic [8:0] read_index;
  logic [3:0] step_counter;

  // pipe: first byte arriving, second byte arriving
  logic        p1_valid;
  logic [1:0]  p1_drum;
  logic        p2_valid;
  logic [1:0]  p2_drum;
  chan_t       p2_wave;

  // output register
  logic [1:0]  out_drum;
  chan_t       out_pulse;
  chan_t       out_wave;

  ram_req_t    ram_req;
  logic [7:0]  rdata;

  logic        s_fire;
  logic        tick_go;
  logic        load_go;
  logic        out_free;
  logic        p1_wave;
  logic        p1_to_p2;
  logic        p1_to_out;
  logic        wrap;
  logic [8:0]  idx;
  logic [3:0]  step;
  logic [1:0]  drum;
  chan_t       lk_first;
  chan_t       lk_second;

  tnds_song_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // handshake and pipe flow
  assign out_free  = !m_tvalid || m_tready;
  assign p1_wave   = rdata[7];
  assign p1_to_p2  = p1_valid && p1_wave && (!p2_valid || out_free);
  assign p1_to_out = p1_valid && !p1_wave && !p2_valid && out_free;
  assign s_tready  = !(p2_valid && !out_free) && !(p1_valid && (p1_wave || !out_free));
  assign s_fire    = s_tvalid && s_tready;
  assign tick_go   = s_fire && (s_tuser == OP_TICK) && playing;
  assign load_go   = s_fire && (s_tuser == OP_LOAD);

  // end-of-song wrap and drum pick
  always_comb begin
    wrap = (read_index >= song_length);
    idx  = wrap ? 9'd0 : read_index;
    step = wrap ? 4'd0 : step_counter;
    if (bass_pattern[step]) begin
      drum = DRUM_BASS;
    end else if (snare_pattern[step]) begin
      drum = DRUM_SNARE;
    end else if (hit_mask[step]) begin
      drum = DRUM_HIT;
    end else begin
      drum = DRUM_NONE;
    end
  end

  // memory requests: loads write, ticks and wave bytes read
  always_comb begin
    ram_req.we    = load_go;
    ram_req.waddr = ADDR_W'(s_tdata[7:0]);
    ram_req.wdata = s_tdata[15:8];
    ram_req.re    = tick_go || p1_to_p2;
    ram_req.raddr = p1_to_p2 ? ADDR_W'(read_index) : ADDR_W'(idx);
  end

  // table lookups on the byte just read
  assign lk_first  = note_lookup({1'b0, rdata[6:0]});
  assign lk_second = note_lookup(rdata);

  // configuration and position
  always_ff @(posedge clk) begin
    if (rst) begin
      playing       <= 1'b0;
      song_length   <= '0;
      bass_pattern  <= '0;
      snare_pattern <= '0;
      hit_mask      <= '0;
      read_index    <= '0;
      step_counter  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLAYING: begin
          playing      <= cfg_data[0];
          read_index   <= '0;
          step_counter <= '0;
        end
        CFG_SONG_LENGTH: song_length   <= cfg_data[8:0];
        CFG_BASS:        bass_pattern  <= cfg_data;
        CFG_SNARE:       snare_pattern <= cfg_data;
        CFG_HIT:         hit_mask      <= cfg_data;
        default: ;
      endcase
    end else if (p1_to_p2) begin
      read_index <= read_index + 9'd1;
    end else if (tick_go) begin
      read_index   <= idx + 9'd1;
      step_counter <= step + 4'd1;
    end
  end

  // pipe valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (tick_go) begin
        p1_valid <= 1'b1;
      end else if (p1_to_p2 || p1_to_out) begin
        p1_valid <= 1'b0;
      end
      if (p1_to_p2) begin
        p2_valid <= 1'b1;
      end else if (out_free) begin
        p2_valid <= 1'b0;
      end
      if (out_free) begin
        m_tvalid <= p2_valid || p1_to_out;
      end
    end
  end

  // pipe payload
  always_ff @(posedge clk) begin
    if (tick_go) begin
      p1_drum <= drum;
    end
    if (p1_to_p2) begin
      p2_drum <= p1_drum;
      p2_wave <= lk_first;
    end
    if (out_free) begin
      if (p2_valid) begin
        out_drum  <= p2_drum;
        out_pulse <= lk_second;
        out_wave  <= p2_wave;
      end else begin
        out_drum  <= p1_drum;
        out_pulse <= lk_second;
        out_wave  <= '0;
      end
    end
  end

  assign m_tdata = {6'd0, out_wave.freq, out_wave.trig,
                    out_pulse.freq, out_pulse.trig, out_drum};

endmodule

/* design/tnds_song_ram.sv */
module tnds_song_ram
  import tnds_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [SONG_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
